// File: hdl/zkb_pkg.sv
// Shared types, codes and constants of the zoom keyed scanline blit unit.
`default_nettype none

package zkb_pkg;

    // Field widths
    localparam int COLOUR_W = 24;
    localparam int INDEX_W  = 8;
    localparam int MODE_W   = 2;
    localparam int ZOOM_W   = 5;
    localparam int ROW_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Parameter defaults
    localparam int DEF_MAX_ZOOM        = 16;
    localparam int DEF_MAX_ROW_WIDTH   = 4096;
    localparam int DEF_PALETTE_ENTRIES = 256;

    // Front-to-back queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Input word commands
    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    // Blit modes
    localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEYED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MATTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_INDEXED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ZOOM         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOUR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATTE_COLOUR   = 3'd5;

    // Configuration reset values
    localparam logic [MODE_W-1:0]   RST_BLIT_MODE      = MODE_COPY;
    localparam logic                RST_SOURCE_INDEXED = 1'b1;
    localparam logic [ZOOM_W-1:0]   RST_X_ZOOM         = 5'd1;
    localparam logic [ROW_W-1:0]    RST_ROW_WIDTH      = 13'd256;
    localparam logic [COLOUR_W-1:0] RST_KEY_COLOUR     = 24'd0;
    localparam logic [COLOUR_W-1:0] RST_MATTE_COLOUR   = 24'd0;

    typedef struct packed {
        logic [MODE_W-1:0]   blit_mode;
        logic                source_indexed;
        logic [ZOOM_W-1:0]   x_zoom;
        logic [ROW_W-1:0]    row_width;
        logic [COLOUR_W-1:0] key_colour;
        logic [COLOUR_W-1:0] matte_colour;
    } cfg_t;

    // One classified source pixel handed from front to back
    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                we;
    } pix_t;

endpackage

`default_nettype wire

// File: hdl/zkb_front.sv
// Front end: accepts input words, keeps the palette RAM and classifies pixels.
`default_nettype none

module zkb_front
    import zkb_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [COLOUR_W-1:0] source_pixel,
    input  wire logic [INDEX_W-1:0]  palette_index,
    input  wire logic [COLOUR_W-1:0] palette_colour,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output pix_t                     push_data
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [COLOUR_W-1:0] pal_mem [PALETTE_ENTRIES];
    logic [COLOUR_W-1:0] pal_rd_reg;
    logic                pal_oor_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [COLOUR_W-1:0] s1_src_reg;

    logic                accept;
    logic                pix_acc;
    logic                push;
    logic                wr_in_range;
    logic                rd_in_range;
    logic                is_key;
    logic [COLOUR_W-1:0] src_colour;
    pix_t                result;

    // Accept a word while the stage is free or drains this cycle
    assign in_ready = !s1_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign pix_acc  = accept && (cmd == CMD_PIXEL);
    assign push     = s1_valid_reg && push_ready;

    assign wr_in_range = {1'b0, palette_index} < (INDEX_W+1)'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, source_pixel[INDEX_W-1:0]} < (INDEX_W+1)'(PALETTE_ENTRIES);

    // Palette RAM: write on palette words, registered read on pixel words
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_PALETTE) && wr_in_range)
        begin
            pal_mem[palette_index[PAL_AW-1:0]] <= palette_colour;
        end
        if (pix_acc)
        begin
            pal_rd_reg  <= pal_mem[source_pixel[PAL_AW-1:0]];
            pal_oor_reg <= !rd_in_range;
            s1_src_reg  <= source_pixel;
        end
    end

    // Hold the pixel stage until the queue takes it
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pix_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Compare against the key and pick the source colour
    always_comb
    begin
        if (cfg.source_indexed)
        begin
            is_key     = s1_src_reg[INDEX_W-1:0] == cfg.key_colour[INDEX_W-1:0];
            src_colour = pal_oor_reg ? '0 : pal_rd_reg;
        end
        else
        begin
            is_key     = s1_src_reg == cfg.key_colour;
            src_colour = s1_src_reg;
        end
    end

    // Decode the blit mode into colour and write enable
    always_comb
    begin
        result.colour = src_colour;
        result.we     = 1'b1;
        unique case (cfg.blit_mode)
            MODE_KEYED:
            begin
                result.we = !is_key;
            end
            MODE_MATTE:
            begin
                result.we     = !is_key;
                result.colour = cfg.matte_colour;
            end
            default:
            begin
                result.we = 1'b1;
            end
        endcase
        if (!result.we)
        begin
            result.colour = '0;
        end
    end

    assign push_valid = s1_valid_reg;
    assign push_data  = result;

endmodule

`default_nettype wire

// File: hdl/zkb_queue.sv
// Short queue of classified pixels between the front and the back.
`default_nettype none

module zkb_queue
    import zkb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire pix_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output pix_t      pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pix_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/zkb_back.sv
// Back end: repeats each pixel by the zoom, tracks the row position, drives results.
`default_nettype none

module zkb_back
    import zkb_pkg::*;
#(
    parameter int MAX_ZOOM      = DEF_MAX_ZOOM,
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire pix_t                pop_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COLOUR_W-1:0]      out_colour,
    output logic                     write_enable,
    output logic                     row_end,
    output logic                     run_last
);

    // The zoom field saturates at sixteen repeats as well as at MAX_ZOOM
    localparam int ZOOM_LIM  = (MAX_ZOOM < 16) ? MAX_ZOOM : 16;
    localparam int ZW        = $clog2(ZOOM_LIM + 1);
    localparam int ROW_MAX   = (1 << ROW_W) - 1;
    localparam int WIDTH_LIM = (MAX_ROW_WIDTH < ROW_MAX) ? MAX_ROW_WIDTH : ROW_MAX;

    logic                busy_reg;
    logic                busy_next;
    logic [ZW-1:0]       k_reg;
    logic [ZW-1:0]       k_next;
    pix_t                held_reg;
    logic [ROW_W-1:0]    pos_reg;
    logic [ROW_W-1:0]    pos_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic                write_enable_reg;
    logic                row_end_reg;
    logic                run_last_reg;

    logic [ZW-1:0]       zoom_eff;
    logic [ROW_W-1:0]    width_eff;
    logic                emit;
    logic                pop;
    pix_t                act;
    logic [ZW-1:0]       act_k;
    logic [ZW-1:0]       k_inc;
    logic                end_w;
    logic                last_w;

    // Saturate zoom and row width
    always_comb
    begin
        if (cfg.x_zoom == '0)
        begin
            zoom_eff = ZW'(1);
        end
        else if (cfg.x_zoom > ZOOM_W'(ZOOM_LIM))
        begin
            zoom_eff = ZW'(ZOOM_LIM);
        end
        else
        begin
            zoom_eff = ZW'(cfg.x_zoom);
        end

        if (cfg.row_width == '0)
        begin
            width_eff = ROW_W'(1);
        end
        else if (cfg.row_width > ROW_W'(WIDTH_LIM))
        begin
            width_eff = ROW_W'(WIDTH_LIM);
        end
        else
        begin
            width_eff = cfg.row_width;
        end
    end

    // Pick the active pixel: the held one mid-run, else the queue head
    assign emit  = (busy_reg || pop_valid) && (!out_valid_reg || out_ready);
    assign pop   = emit && !busy_reg;
    assign pop_ready = !busy_reg && (!out_valid_reg || out_ready);
    assign act   = busy_reg ? held_reg : pop_data;
    assign act_k = busy_reg ? k_reg : '0;
    assign k_inc = act_k + ZW'(1);

    // Row end and run end of the repeat being emitted
    assign end_w  = ({1'b0, pos_reg} + (ROW_W+1)'(1)) >= {1'b0, width_eff};
    assign last_w = end_w || (k_inc == zoom_eff);

    // Advance the run and the row position
    always_comb
    begin
        busy_next      = busy_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            busy_next      = !last_w;
            k_next         = k_inc;
            pos_next       = end_w ? '0 : pos_reg + ROW_W'(1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register and hold the popped pixel for its run
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            held_reg <= pop_data;
        end
        if (emit)
        begin
            out_colour_reg   <= act.colour;
            write_enable_reg <= act.we;
            row_end_reg      <= end_w;
            run_last_reg     <= last_w;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_colour   = out_colour_reg;
    assign write_enable = write_enable_reg;
    assign row_end      = row_end_reg;
    assign run_last     = run_last_reg;

endmodule

`default_nettype wire

// File: hdl/zoom_keyed_scanline_blit_unit.sv
// Top level of the zoom keyed scanline blit unit: configuration, front, queue, back.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------------------------------
//   in      | input     | in_valid / in_ready  | cmd, source_pixel, palette_index, palette_colour
//   out     | output    | out_valid / out_ready| out_colour, write_enable, row_end, run_last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The back end emits one result per cycle while the output is not stalled, so a source
// pixel occupies it for its zoom count (1 to 16 repeats, fewer where the row ends); palette words never reach it.
// A pixel word passes the palette read register, the queue and the result register before
// its first result is on the output. A four-word queue lets the front keep accepting
// while the back is busy or the output stalls. Reset clears control state and the row
// position; the palette RAM holds nothing defined until written. cfg_ready is always high.
`default_nettype none

module zoom_keyed_scanline_blit_unit
    import zkb_pkg::*;
#(
    parameter int MAX_ZOOM        = DEF_MAX_ZOOM,
    parameter int MAX_ROW_WIDTH   = DEF_MAX_ROW_WIDTH,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  cmd,
    input  wire logic [COLOUR_W-1:0]   source_pixel,
    input  wire logic [INDEX_W-1:0]    palette_index,
    input  wire logic [COLOUR_W-1:0]   palette_colour,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COLOUR_W-1:0]        out_colour,
    output logic                       write_enable,
    output logic                       row_end,
    output logic                       run_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MODE_W-1:0]   blit_mode_reg;
    logic                source_indexed_reg;
    logic [ZOOM_W-1:0]   x_zoom_reg;
    logic [ROW_W-1:0]    row_width_reg;
    logic [COLOUR_W-1:0] key_colour_reg;
    logic [COLOUR_W-1:0] matte_colour_reg;
    cfg_t                cfg;

    logic                push_valid;
    logic                push_ready;
    pix_t                push_data;
    logic                pop_valid;
    logic                pop_ready;
    pix_t                pop_data;

    assign cfg_ready = 1'b1;

    // Decode configuration writes; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blit_mode_reg      <= RST_BLIT_MODE;
            source_indexed_reg <= RST_SOURCE_INDEXED;
            x_zoom_reg         <= RST_X_ZOOM;
            row_width_reg      <= RST_ROW_WIDTH;
            key_colour_reg     <= RST_KEY_COLOUR;
            matte_colour_reg   <= RST_MATTE_COLOUR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLIT_MODE:      blit_mode_reg      <= cfg_data[MODE_W-1:0];
                REG_SOURCE_INDEXED: source_indexed_reg <= cfg_data[0];
                REG_X_ZOOM:         x_zoom_reg         <= cfg_data[ZOOM_W-1:0];
                REG_ROW_WIDTH:      row_width_reg      <= cfg_data[ROW_W-1:0];
                REG_KEY_COLOUR:     key_colour_reg     <= cfg_data[COLOUR_W-1:0];
                REG_MATTE_COLOUR:   matte_colour_reg   <= cfg_data[COLOUR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.blit_mode      = blit_mode_reg;
        cfg.source_indexed = source_indexed_reg;
        cfg.x_zoom         = x_zoom_reg;
        cfg.row_width      = row_width_reg;
        cfg.key_colour     = key_colour_reg;
        cfg.matte_colour   = matte_colour_reg;
    end

    zkb_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .source_pixel   (source_pixel),
        .palette_index  (palette_index),
        .palette_colour (palette_colour),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    zkb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    zkb_back #(
        .MAX_ZOOM      (MAX_ZOOM),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_colour   (out_colour),
        .write_enable (write_enable),
        .row_end      (row_end),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

// File: test/zoom_keyed_scanline_blit_unit_test.sv
// Self-checking testbench of the zoom keyed scanline blit unit: random and directed words.
module zoom_keyed_scanline_blit_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import zkb_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_WORDS  = 420;
    localparam int IDLE_PCT      = 15;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int CALM_FROM     = 1500;
    localparam int CALM_TO       = 2300;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 240;
    localparam int HOLD_BACKLOG  = 16;

    // Codes the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                cmd;
        logic [COLOUR_W-1:0] source_pixel;
        logic [INDEX_W-1:0]  palette_index;
        logic [COLOUR_W-1:0] palette_colour;
    } blit_word_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                we;
        logic                row_end;
        logic                run_last;
    } dest_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  cmd = CMD_PIXEL;
    logic [COLOUR_W-1:0]   source_pixel = '0;
    logic [INDEX_W-1:0]    palette_index = '0;
    logic [COLOUR_W-1:0]   palette_colour = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COLOUR_W-1:0]   out_colour;
    logic                  write_enable;
    logic                  row_end;
    logic                  run_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the configuration and state of the block
    logic [MODE_W-1:0]   mode_now    = RST_BLIT_MODE;
    logic                indexed_now = RST_SOURCE_INDEXED;
    logic [ZOOM_W-1:0]   zoom_now    = RST_X_ZOOM;
    logic [ROW_W-1:0]    width_now   = RST_ROW_WIDTH;
    logic [COLOUR_W-1:0] key_now     = RST_KEY_COLOUR;
    logic [COLOUR_W-1:0] matte_now   = RST_MATTE_COLOUR;
    logic [COLOUR_W-1:0] palette_shadow [256];
    logic [ROW_W-1:0]    row_pos = '0;

    blit_word_t  source_words [$];
    dest_pixel_t dest_pixels_due [$];
    blit_word_t  offered;

    // Palette entries written so far, in stimulus order
    logic              palette_loaded [256];
    logic [INDEX_W-1:0] loaded_idx [$];

    int  fail_count = 0;
    int  results_taken = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;
    int  cycles_run = 0;
    logic calm;

    assign calm = cycles_run >= CALM_FROM && cycles_run < CALM_TO;

    zoom_keyed_scanline_blit_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .source_pixel   (source_pixel),
        .palette_index  (palette_index),
        .palette_colour (palette_colour),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_colour     (out_colour),
        .write_enable   (write_enable),
        .row_end        (row_end),
        .run_last       (run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Expand one accepted word into the destination pixels it should produce
    task automatic zoom_word(input blit_word_t w);
        dest_pixel_t         px;
        int unsigned         reps;
        int unsigned         span;
        int unsigned         k;
        logic                hit;
        logic [COLOUR_W-1:0] colour;
        if (w.cmd == CMD_PALETTE)
        begin
            palette_shadow[w.palette_index] = w.palette_colour;
            return;
        end
        reps = (zoom_now == 0) ? 1 : zoom_now;
        if (reps > DEF_MAX_ZOOM)
            reps = DEF_MAX_ZOOM;
        span = (width_now == 0) ? 1 : width_now;
        if (span > DEF_MAX_ROW_WIDTH)
            span = DEF_MAX_ROW_WIDTH;
        if (indexed_now)
        begin
            hit = w.source_pixel[INDEX_W-1:0] == key_now[INDEX_W-1:0];
            colour = palette_shadow[w.source_pixel[INDEX_W-1:0]];
        end
        else
        begin
            hit = w.source_pixel == key_now;
            colour = w.source_pixel;
        end
        // Unused mode falls through to plain copy
        px.we = 1'b1;
        if (mode_now == MODE_KEYED)
            px.we = !hit;
        else if (mode_now == MODE_MATTE)
        begin
            px.we = !hit;
            colour = matte_now;
        end
        px.colour = px.we ? colour : '0;
        // Cut the run short at the row end, wrapping the position
        for (k = 0; k < reps; k++)
        begin
            px.row_end = (int'(row_pos) + 1) >= span;
            px.run_last = px.row_end || (k + 1 == reps);
            dest_pixels_due.push_back(px);
            if (px.row_end)
            begin
                row_pos = '0;
                break;
            end
            row_pos = row_pos + 1'b1;
        end
    endtask

    // Driver: offer pending words, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                zoom_word(offered);
            if (!in_valid || in_ready)
            begin
                if (source_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    offered = source_words.pop_front();
                    in_valid       <= 1'b1;
                    cmd            <= offered.cmd;
                    source_pixel   <= offered.source_pixel;
                    palette_index  <= offered.palette_index;
                    palette_colour <= offered.palette_colour;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        dest_pixel_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (dest_pixels_due.size() == 0)
                begin
                    $display("%0t: unexpected word: colour %h we %b end %b last %b", $time,
                             out_colour, write_enable, row_end, run_last);
                    fail_count++;
                end
                else
                begin
                    want = dest_pixels_due.pop_front();
                    if (out_colour !== want.colour)
                    begin
                        $display("%0t: out_colour expected %h actual %h", $time,
                                 want.colour, out_colour);
                        fail_count++;
                    end
                    if (write_enable !== want.we)
                    begin
                        $display("%0t: write_enable expected %b actual %b", $time,
                                 want.we, write_enable);
                        fail_count++;
                    end
                    if (row_end !== want.row_end)
                    begin
                        $display("%0t: row_end expected %b actual %b", $time,
                                 want.row_end, row_end);
                        fail_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.run_last, run_last);
                        fail_count++;
                    end
                end
            end
            // Hold off once for a long stretch while plenty of words wait to be sent
            if (!hold_done && results_taken >= HOLD_AT && source_words.size() > HOLD_BACKLOG)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            // Otherwise stall at random
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Track register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLIT_MODE:      mode_now    <= cfg_data[MODE_W-1:0];
                REG_SOURCE_INDEXED: indexed_now <= cfg_data[0];
                REG_X_ZOOM:         zoom_now    <= cfg_data[ZOOM_W-1:0];
                REG_ROW_WIDTH:      width_now   <= cfg_data[ROW_W-1:0];
                REG_KEY_COLOUR:     key_now     <= cfg_data;
                REG_MATTE_COLOUR:   matte_now   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("zoom_keyed_scanline_blit_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_palette(input logic [INDEX_W-1:0] idx, input logic [COLOUR_W-1:0] rgb);
        blit_word_t w;
        w = '{cmd: CMD_PALETTE, source_pixel: 24'($urandom), palette_index: idx,
              palette_colour: rgb};
        if (!palette_loaded[idx])
        begin
            palette_loaded[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
        source_words.push_back(w);
    endtask

    task automatic push_pixel(input logic [COLOUR_W-1:0] src);
        blit_word_t w;
        w = '{cmd: CMD_PIXEL, source_pixel: src, palette_index: 8'($urandom),
              palette_colour: 24'($urandom)};
        source_words.push_back(w);
    endtask

    // Wait for every word to be taken and every result to arrive, then let the pipe empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (source_words.size() != 0 || in_valid || dest_pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                  random_words;
        int                  n;
        int                  roll;
        logic [COLOUR_W-1:0] junk;
        logic [MODE_W-1:0]   mode_pick;
        logic                indexed_pick;
        logic [ZOOM_W-1:0]   zoom_pick;
        logic [ROW_W-1:0]    width_pick;
        logic [COLOUR_W-1:0] key_pick;
        logic [INDEX_W-1:0]  idx;

        random_words = 0;
        foreach (palette_loaded[i])
            palette_loaded[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: indexed plain copy, palette extremes loaded first
        push_palette(8'h00, 24'hFFFFFF);
        push_palette(8'hFF, 24'h000000);
        push_palette(8'h5A, 24'hA5A5A5);
        push_palette(8'hA5, 24'h5A5A5A);
        push_pixel(24'hFFFF00);
        push_pixel(24'h0000FF);
        push_pixel(24'h12345A);
        wait_drained();

        // Keyed indexed at full zoom: only the low byte of the key counts
        write_reg(REG_BLIT_MODE, {22'd0, MODE_KEYED});
        write_reg(REG_X_ZOOM, 24'd16);
        write_reg(REG_ROW_WIDTH, 24'd4096);
        write_reg(REG_KEY_COLOUR, 24'hFFFF5A);
        push_pixel(24'h00005A);
        push_pixel(24'hFFFF5A);
        push_pixel(24'h0000A5);
        wait_drained();

        // Matte on RGB, zoom beyond the limit, zero row width
        write_reg(REG_SOURCE_INDEXED, 24'd0);
        write_reg(REG_BLIT_MODE, {22'd0, MODE_MATTE});
        write_reg(REG_X_ZOOM, 24'd31);
        write_reg(REG_ROW_WIDTH, 24'd0);
        write_reg(REG_KEY_COLOUR, 24'hFFFFFF);
        write_reg(REG_MATTE_COLOUR, 24'h123456);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFE);
        wait_drained();

        // Unused mode, zero zoom, oversized row; spare register indexes ignored
        write_reg(REG_BLIT_MODE, {22'd0, MODE_SPARE});
        write_reg(REG_X_ZOOM, 24'd0);
        write_reg(REG_ROW_WIDTH, 24'd8191);
        write_reg(REG_SPARE_6, 24'($urandom));
        write_reg(REG_SPARE_7, 24'($urandom));
        push_palette(8'h80, 24'h800000);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        wait_drained();

        // Long runs to push the row position along
        write_reg(REG_BLIT_MODE, {22'd0, MODE_COPY});
        write_reg(REG_X_ZOOM, 24'd16);
        write_reg(REG_ROW_WIDTH, 24'd4096);
        push_pixel(24'h0F0F0F);
        push_pixel(24'hF0F0F0);
        wait_drained();

        // Shrink the row below the position, then wrap mid-run
        write_reg(REG_BLIT_MODE, {22'd0, MODE_KEYED});
        write_reg(REG_X_ZOOM, 24'd5);
        write_reg(REG_ROW_WIDTH, 24'd7);
        write_reg(REG_KEY_COLOUR, 24'h00FF00);
        push_pixel(24'h00FF00);
        push_pixel(24'h00FF01);
        push_pixel(24'h00FF00);
        push_pixel(24'h7FFFFF);
        wait_drained();

        // Random phases, each with fresh settings
        while (random_words < RANDOM_WORDS)
        begin
            mode_pick = 2'($urandom_range(3));
            indexed_pick = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 70)
                zoom_pick = 5'($urandom_range(1, 4));
            else if (roll < 85)
                zoom_pick = 5'($urandom_range(5, 16));
            else if (roll < 93)
                zoom_pick = 5'd16;
            else if (roll < 97)
                zoom_pick = 5'd0;
            else
                zoom_pick = 5'($urandom_range(17, 31));
            roll = $urandom_range(99);
            if (roll < 50)
                width_pick = 13'($urandom_range(1, 24));
            else if (roll < 80)
                width_pick = 13'($urandom_range(25, 300));
            else if (roll < 90)
                width_pick = 13'd4096;
            else if (roll < 95)
                width_pick = 13'($urandom_range(4097, 8191));
            else
                width_pick = 13'd0;
            // An indexed key must name a loaded entry, since key pixels still read it
            if (indexed_pick)
                key_pick = {16'($urandom), loaded_idx[$urandom_range(loaded_idx.size() - 1)]};
            else
                key_pick = 24'($urandom);

            // Upper data bits beyond each register are don't-care
            junk = 24'($urandom);
            write_reg(REG_BLIT_MODE, {junk[COLOUR_W-1:MODE_W], mode_pick});
            junk = 24'($urandom);
            write_reg(REG_SOURCE_INDEXED, {junk[COLOUR_W-1:1], indexed_pick});
            junk = 24'($urandom);
            write_reg(REG_X_ZOOM, {junk[COLOUR_W-1:ZOOM_W], zoom_pick});
            junk = 24'($urandom);
            write_reg(REG_ROW_WIDTH, {junk[COLOUR_W-1:ROW_W], width_pick});
            write_reg(REG_KEY_COLOUR, key_pick);
            write_reg(REG_MATTE_COLOUR, 24'($urandom));

            n = $urandom_range(25, 45);
            repeat (n)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                    push_palette(8'($urandom), 24'($urandom));
                else if (indexed_pick)
                begin
                    if ($urandom_range(99) < 30)
                        idx = key_pick[INDEX_W-1:0];
                    else
                        idx = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
                    push_pixel({16'($urandom), idx});
                end
                else if (roll < 40)
                    push_pixel(key_pick);
                else if (roll < 45)
                    push_pixel($urandom_range(1) ? 24'hFFFFFF : 24'h000000);
                else
                    push_pixel(24'($urandom));
            end
            random_words += n;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("zoom_keyed_scanline_blit_unit test passed");
        else
            $display("zoom_keyed_scanline_blit_unit test failed");
        $finish;
    end

endmodule
